FILE: hw/rtl/lei_pkg.sv
// Shared types, constants and the microcode program of the Lorenz Euler integrator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lei_pkg;

  // Number format and counter widths
  localparam int VALUE_W   = 32;
  localparam int FRAC_BITS = 20;
  localparam int COUNT_W   = 16;
  localparam int DT_W      = VALUE_W - 1;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;

  // Microcode program length
  localparam int N_STEPS = 8;
  localparam int PC_W    = $clog2(N_STEPS);

  // Port widths
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = VALUE_W;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((3 * VALUE_W + 7) / 8) * 8;

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic [COUNT_W-1:0]        cnt_t;
  typedef logic [DT_W-1:0]           dt_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA   = 3'd0,
    REG_RHO     = 3'd1,
    REG_BETA    = 3'd2,
    REG_DT      = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6,
    REG_RUN_LEN = 3'd7
  } reg_idx_t;

  // Reset values of the configuration registers
  localparam val_t RST_SIGMA   = VALUE_W'(10485760);
  localparam val_t RST_RHO     = VALUE_W'(29360128);
  localparam val_t RST_BETA    = VALUE_W'(2796203);
  localparam dt_t  RST_DT      = DT_W'(10486);
  localparam val_t RST_START_X = VALUE_W'(104858);
  localparam val_t RST_START_Y = '0;
  localparam val_t RST_START_Z = '0;
  localparam cnt_t RST_RUN_LEN = COUNT_W'(5000);

  // Operand sources of the datapath
  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_SIGMA, SRC_RHO, SRC_BETA, SRC_DT,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3
  } src_t;

  // Result destinations of the datapath
  typedef enum logic [2:0] {
    DST_NONE, DST_X, DST_Y, DST_Z, DST_T0, DST_T1, DST_T2, DST_T3
  } dst_t;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_t;
  typedef enum logic {JMP_NEXT, JMP_END} jmp_t;

  // One control word: an add/sub slot and a multiply slot issue together
  typedef struct packed {
    alu_op_t a_op;
    src_t    a_src1;
    src_t    a_src2;
    dst_t    a_dst;
    src_t    m_src1;
    src_t    m_src2;
    dst_t    m_dst;
    jmp_t    jmp;
  } uword_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    uword_t uw;
    logic   fire;
  } ctrl_t;

  // Euler step program. Temporaries:
  //   T0: y-x, then dx, then dt*dx    T1: x*y, then dz, then dt*dz
  //   T2: rho-z, then x*(rho-z), dy, dt*dy    T3: beta*z
  function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
    uword_t uw;
    uw = '{ALU_ADD, SRC_X, SRC_X, DST_NONE, SRC_X, SRC_X, DST_NONE, JMP_END};
    unique case (pc)
      3'd0: uw = '{ALU_SUB, SRC_Y,   SRC_X,  DST_T0,   SRC_X,     SRC_Y,  DST_T1,   JMP_NEXT};
      3'd1: uw = '{ALU_SUB, SRC_RHO, SRC_Z,  DST_T2,   SRC_BETA,  SRC_Z,  DST_T3,   JMP_NEXT};
      3'd2: uw = '{ALU_SUB, SRC_T1,  SRC_T3, DST_T1,   SRC_SIGMA, SRC_T0, DST_T0,   JMP_NEXT};
      3'd3: uw = '{ALU_ADD, SRC_X,   SRC_X,  DST_NONE, SRC_X,     SRC_T2, DST_T2,   JMP_NEXT};
      3'd4: uw = '{ALU_SUB, SRC_T2,  SRC_Y,  DST_T2,   SRC_DT,    SRC_T0, DST_T0,   JMP_NEXT};
      3'd5: uw = '{ALU_ADD, SRC_X,   SRC_T0, DST_X,    SRC_DT,    SRC_T1, DST_T1,   JMP_NEXT};
      3'd6: uw = '{ALU_ADD, SRC_Z,   SRC_T1, DST_Z,    SRC_DT,    SRC_T2, DST_T2,   JMP_NEXT};
      3'd7: uw = '{ALU_ADD, SRC_Y,   SRC_T2, DST_Y,    SRC_X,     SRC_X,  DST_NONE, JMP_END};
      default: ;
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lei_seq.sv
// Microcode sequencer: step counter, control store lookup and the end-of-program jump.
// Depends on lei_pkg for the control word types and the program.
`timescale 1ns / 1ps
`default_nettype none

module lei_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          out_free,
  output lei_pkg::ctrl_t     ctrl,
  output logic               busy
);
  import lei_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  uword_t          uw;
  logic            fire;
  logic            at_end;

  // Fetch the control word; the last step holds until the output slot frees up
  assign uw     = ucode_rom(pc_r);
  assign at_end = (uw.jmp == JMP_END);
  assign fire   = busy_r && (!at_end || out_free);

  assign ctrl = '{uw: uw, fire: fire};
  assign busy = busy_r;

  // Advance the step counter, return to step zero at the end
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (fire) begin
      if (at_end) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Idle sequencer always sits at the program entry
  a_idle_pc0: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pc_r == '0)
    else $error("sequencer idle away from step zero");

  // Finishing the program drops busy
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && at_end && !start) |=> !busy_r)
    else $error("sequencer still busy after final step");

  // A start never arrives while a program runs
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("start while sequencer busy");

endmodule

`default_nettype wire

FILE: hw/rtl/lei_datapath.sv
// Datapath: position and temporary registers, one saturating add/sub unit and one
// saturating Q-format multiplier. Depends on lei_pkg for types and control words.
`timescale 1ns / 1ps
`default_nettype none

module lei_datapath (
  input  wire logic           clk,
  input  wire lei_pkg::ctrl_t ctrl,
  input  wire logic           load,
  input  wire lei_pkg::val_t  start_x,
  input  wire lei_pkg::val_t  start_y,
  input  wire lei_pkg::val_t  start_z,
  input  wire lei_pkg::val_t  sigma,
  input  wire lei_pkg::val_t  rho,
  input  wire lei_pkg::val_t  beta,
  input  wire lei_pkg::dt_t   dt,
  output lei_pkg::val_t       pos_x,
  output lei_pkg::val_t       pos_y,
  output lei_pkg::val_t       pos_z,
  output lei_pkg::val_t       y_next
);
  import lei_pkg::*;

  localparam val_t VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  val_t x_r, y_r, z_r, t0_r, t1_r, t2_r, t3_r;
  val_t x_nxt, y_nxt, z_nxt, t0_nxt, t1_nxt, t2_nxt, t3_nxt;

  val_t a_op1, a_op2, m_op1, m_op2;
  logic [VALUE_W:0]        sum;
  val_t                    alu_res;
  logic signed [PROD_W-1:0] prod;
  logic [SHIFT_W-1:0]      shifted;
  logic [SHIFT_W-VALUE_W:0] upper;
  val_t                    mul_res;

  // Select one operand
  function automatic val_t pick(src_t s, val_t x, val_t y, val_t z, val_t t0, val_t t1,
                                val_t t2, val_t t3, val_t sg, val_t rh, val_t bt, dt_t d);
    val_t v;
    v = x;
    case (s)
      SRC_X:     v = x;
      SRC_Y:     v = y;
      SRC_Z:     v = z;
      SRC_SIGMA: v = sg;
      SRC_RHO:   v = rh;
      SRC_BETA:  v = bt;
      SRC_DT:    v = {1'b0, d};
      SRC_T0:    v = t0;
      SRC_T1:    v = t1;
      SRC_T2:    v = t2;
      SRC_T3:    v = t3;
      default:   v = x;
    endcase
    return v;
  endfunction

  assign a_op1 = pick(ctrl.uw.a_src1, x_r, y_r, z_r, t0_r, t1_r, t2_r, t3_r, sigma, rho, beta, dt);
  assign a_op2 = pick(ctrl.uw.a_src2, x_r, y_r, z_r, t0_r, t1_r, t2_r, t3_r, sigma, rho, beta, dt);
  assign m_op1 = pick(ctrl.uw.m_src1, x_r, y_r, z_r, t0_r, t1_r, t2_r, t3_r, sigma, rho, beta, dt);
  assign m_op2 = pick(ctrl.uw.m_src2, x_r, y_r, z_r, t0_r, t1_r, t2_r, t3_r, sigma, rho, beta, dt);

  // Saturating add/sub on one guard bit
  always_comb begin
    if (ctrl.uw.a_op == ALU_SUB) begin
      sum = {a_op1[VALUE_W-1], a_op1} - {a_op2[VALUE_W-1], a_op2};
    end else begin
      sum = {a_op1[VALUE_W-1], a_op1} + {a_op2[VALUE_W-1], a_op2};
    end
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      alu_res = sum[VALUE_W] ? VMIN : VMAX;
    end else begin
      alu_res = sum[VALUE_W-1:0];
    end
  end

  // Full product, drop fraction bits (floor), clamp to the value range
  assign prod    = PROD_W'(m_op1) * PROD_W'(m_op2);
  assign shifted = prod[PROD_W-1:FRAC_BITS];
  assign upper   = shifted[SHIFT_W-1:VALUE_W-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      mul_res = shifted[VALUE_W-1:0];
    end else begin
      mul_res = prod[PROD_W-1] ? VMIN : VMAX;
    end
  end

  // Reload from the start position or write back the issued results
  always_comb begin
    x_nxt  = x_r;
    y_nxt  = y_r;
    z_nxt  = z_r;
    t0_nxt = t0_r;
    t1_nxt = t1_r;
    t2_nxt = t2_r;
    t3_nxt = t3_r;
    if (load) begin
      x_nxt = start_x;
      y_nxt = start_y;
      z_nxt = start_z;
    end else if (ctrl.fire) begin
      case (ctrl.uw.a_dst)
        DST_X:   x_nxt  = alu_res;
        DST_Y:   y_nxt  = alu_res;
        DST_Z:   z_nxt  = alu_res;
        DST_T0:  t0_nxt = alu_res;
        DST_T1:  t1_nxt = alu_res;
        DST_T2:  t2_nxt = alu_res;
        DST_T3:  t3_nxt = alu_res;
        default: ;
      endcase
      case (ctrl.uw.m_dst)
        DST_X:   x_nxt  = mul_res;
        DST_Y:   y_nxt  = mul_res;
        DST_Z:   z_nxt  = mul_res;
        DST_T0:  t0_nxt = mul_res;
        DST_T1:  t1_nxt = mul_res;
        DST_T2:  t2_nxt = mul_res;
        DST_T3:  t3_nxt = mul_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    t2_r <= t2_nxt;
    t3_r <= t3_nxt;
  end

  assign pos_x  = x_r;
  assign pos_y  = y_r;
  assign pos_z  = z_r;
  assign y_next = y_nxt;

endmodule

`default_nettype wire

FILE: hw/rtl/lorenz_euler_integrator_top.sv
// After an input transfer the sequencer runs the 8-step program, one microcode step per cycle,
// except that the last step stalls while the output slot is full. A new tick is accepted only
// while the sequencer is idle; the steps share a single multiplier and a single add/sub unit.
// A full output register holds the last step until the result is taken.
// Reset (rst_n low, synchronous): coefficients return to defaults, step count clears, output empties.
`timescale 1ns / 1ps
`default_nettype none

module lorenz_euler_integrator_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration write port
  input  wire logic                               cfg_wr_en,
  input  wire logic [lei_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lei_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lei_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] restart, rest zero
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [lei_pkg::OUT_TDATA_W-1:0]         out_tdata,  // pos_x, pos_y, pos_z
  output logic                                    out_tlast   // last_step
);
  import lei_pkg::*;

  // Configuration registers
  val_t sigma_r, rho_r, beta_r, start_x_r, start_y_r, start_z_r;
  dt_t  dt_r;
  cnt_t run_len_r;

  // Run bookkeeping and output slot
  cnt_t step_cnt_r, step_cnt_nxt;
  logic last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic   in_xfer;
  logic   reload;
  cnt_t   cnt_base;
  cnt_t   cnt_inc;
  logic   out_free;
  logic   out_load;
  logic   busy;
  ctrl_t  ctrl;
  val_t   pos_x, pos_y, pos_z;
  val_t   y_next;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r   <= RST_SIGMA;
      rho_r     <= RST_RHO;
      beta_r    <= RST_BETA;
      dt_r      <= RST_DT;
      start_x_r <= RST_START_X;
      start_y_r <= RST_START_Y;
      start_z_r <= RST_START_Z;
      run_len_r <= RST_RUN_LEN;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SIGMA:   sigma_r   <= cfg_data;
        REG_RHO:     rho_r     <= cfg_data;
        REG_BETA:    beta_r    <= cfg_data;
        REG_DT:      dt_r      <= cfg_data[DT_W-1:0];
        REG_START_X: start_x_r <= cfg_data;
        REG_START_Y: start_y_r <= cfg_data;
        REG_START_Z: start_z_r <= cfg_data;
        REG_RUN_LEN: run_len_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a new tick while the sequencer is idle
  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;
  assign reload    = in_tdata[0] || (step_cnt_r == '0);

  // Count steps of the run at transfer time; wrap to zero on the last one
  assign cnt_base = reload ? '0 : step_cnt_r;
  assign cnt_inc  = cnt_base + COUNT_W'(1);

  always_comb begin
    step_cnt_nxt = step_cnt_r;
    last_nxt     = last_r;
    if (in_xfer) begin
      last_nxt     = (cnt_inc == run_len_r);
      step_cnt_nxt = last_nxt ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= '0;
      last_r     <= 1'b0;
    end else begin
      step_cnt_r <= step_cnt_nxt;
      last_r     <= last_nxt;
    end
  end

  lei_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  lei_datapath u_dp (
    .clk     (clk),
    .ctrl    (ctrl),
    .load    (in_xfer && reload),
    .start_x (start_x_r),
    .start_y (start_y_r),
    .start_z (start_z_r),
    .sigma   (sigma_r),
    .rho     (rho_r),
    .beta    (beta_r),
    .dt      (dt_r),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .pos_z   (pos_z),
    .y_next  (y_next)
  );

  // Output slot: load on the final step, drop on transfer
  assign out_free = !out_valid_r || out_tready;
  assign out_load = ctrl.fire && (ctrl.uw.jmp == JMP_END);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // The final step writes y; take its new value alongside the stored x and z
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {pos_z, y_next, pos_x};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A transfer starts the sequencer
  a_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy)
    else $error("sequencer not started by input transfer");

  // The final step fills the output slot
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("result not presented after final step");

  // The final step never overwrites an unread result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire
